// File: rtl/ptb_pkg.sv
// ptb_pkg: shared constants and the controller state type of the eertree builder
// no dependencies; used by the interfaces, ptb_ram and palindromic_tree_builder_top
package ptb_pkg;

  localparam int MAX_NODES_DEF = 4096;
  localparam int ALPHABET_DEF  = 26;

  localparam int SYM_W   = 5;
  localparam int NODE_W  = 12;
  localparam int LEN_W   = 12;
  localparam int TOTAL_W = 13;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK,
    S_LEN,
    S_TXT,
    S_CRD,
    S_CVER,
    S_CCHK,
    S_MAKE,
    S_EMIT
  } state_t;

endpackage

// File: rtl/ptb_if.sv
// ptb_sym_if and ptb_res_if: valid/ready channels for symbols and results
// depends on ptb_pkg for field widths
interface ptb_sym_if;
  logic                      valid;
  logic                      ready;
  logic [ptb_pkg::SYM_W-1:0] symbol;
  logic                      restart;

  modport source (output valid, symbol, restart, input ready);
  modport sink   (input valid, symbol, restart, output ready);
endinterface

interface ptb_res_if;
  logic                        valid;
  logic                        ready;
  logic [ptb_pkg::NODE_W-1:0]  suffix_node;
  logic [ptb_pkg::LEN_W-1:0]   suffix_length;
  logic                        created;
  logic [ptb_pkg::NODE_W-1:0]  link_node;
  logic [ptb_pkg::TOTAL_W-1:0] node_total;
  logic                        overflow;

  modport source (output valid, suffix_node, suffix_length, created, link_node,
                  node_total, overflow, input ready);
  modport sink   (input valid, suffix_node, suffix_length, created, link_node,
                  node_total, overflow, output ready);
endinterface

// File: rtl/ptb_ram.sv
// ptb_ram: simple dual-port synchronous memory, one write and one registered read port
// depends on ptb_pkg for default sizes
module ptb_ram #(
  parameter int DEPTH = ptb_pkg::MAX_NODES_DEF,
  parameter int WIDTH = ptb_pkg::SYM_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/palindromic_tree_builder_top.sv
// palindromic_tree_builder_top: eertree builder over a letter stream
// depends on ptb_pkg, ptb_sym_if, ptb_res_if and ptb_ram
//
// symbols carries one letter and a restart flag per transfer; results returns one
// item per symbol: longest palindromic suffix node, its length and suffix link,
// a created flag, the node count and an overflow flag.
// text, child slots and node records (link, length, parent, letter) sit in three
// synchronous memories; no memory is cleared: a child slot counts only if the node
// it names is below the node count and records the same parent and letter, text
// below the current position and nodes below the count are always written.
// one symbol at a time: after the accept, each suffix-link hop reads the node, checks
// the length and reads the text; a failed length check skips the text read, and the
// imaginary root skips both; then the child slot is read, its node read and checked,
// and the result is loaded; a new node adds a make step, and unless the walk ended
// at the imaginary root, a second walk along suffix links and a second child lookup
// go first; ignored and overflow symbols go from the accept straight to the load.
// a result waits in the output register while the receiver stalls; the next symbol
// is still taken, and its result is held in the last step until the register frees.
// reset (and restart with a symbol) leaves two roots, empty text, last node 0;
// no clearing pass is needed, so symbols are taken right after reset.
module palindromic_tree_builder_top #(
  parameter int MAX_NODES = ptb_pkg::MAX_NODES_DEF,
  parameter int ALPHABET  = ptb_pkg::ALPHABET_DEF
) (
  input logic       clk,
  input logic       rst,
  ptb_sym_if.sink   symbols,
  ptb_res_if.source results
);

  localparam int NW     = $clog2(MAX_NODES);
  localparam int CW     = $clog2(MAX_NODES + 1);
  localparam int TW     = $clog2(MAX_NODES - 1);
  localparam int LW     = NW + 2;
  localparam int SW     = ptb_pkg::SYM_W;
  localparam int CDEPTH = MAX_NODES * ALPHABET;
  localparam int AW     = $clog2(CDEPTH);
  localparam int MW     = 3 * NW + SW;
  localparam int NODE_OW  = ptb_pkg::NODE_W;
  localparam int LEN_OW   = ptb_pkg::LEN_W;
  localparam int TOTAL_OW = ptb_pkg::TOTAL_W;

  ptb_pkg::state_t state, state_next;

  logic [TW-1:0]        pos;
  logic [CW-1:0]        cnt;
  logic [NW-1:0]        last;
  logic [NW-1:0]        last_len;
  logic [NW-1:0]        last_link;
  logic [SW-1:0]        sym_r;
  logic [NW-1:0]        p;
  logic signed [LW-1:0] p_len;
  logic [NW-1:0]        p_link;
  logic [NW-1:0]        cur;
  logic signed [LW-1:0] cur_len;
  logic [NW-1:0]        cur_link;
  logic [AW-1:0]        cur_slot;
  logic [NW-1:0]        cand;
  logic [NW-1:0]        new_link;
  logic                 second;
  logic                 created_r;
  logic                 over_r;

  logic          text_we;
  logic [TW-1:0] text_waddr;
  logic [SW-1:0] text_wdata;
  logic [TW-1:0] text_raddr;
  logic [SW-1:0] text_q;

  logic          node_we;
  logic [NW-1:0] node_waddr;
  logic [MW-1:0] node_wdata;
  logic [NW-1:0] node_raddr;
  logic [MW-1:0] node_q;

  logic          child_we;
  logic [AW-1:0] child_waddr;
  logic [NW-1:0] child_wdata;
  logic [AW-1:0] child_raddr;
  logic [NW-1:0] child_q;

  logic                 in_fire;
  logic                 sym_ok;
  logic                 full;
  logic [TW-1:0]        pos_eff;
  logic [NW-1:0]        nd_link;
  logic [NW-1:0]        nd_len;
  logic [NW-1:0]        nd_par;
  logic [SW-1:0]        nd_sym;
  logic signed [LW-1:0] lk_len;
  logic [NW-1:0]        lk_link;
  logic signed [LW-1:0] pos_s;
  logic signed [LW-1:0] idx;
  logic                 idx_ok;
  logic                 text_hit;
  logic [AW-1:0]        slot_calc;
  logic                 cand_ok;
  logic [NW-1:0]        new_len;
  logic                 out_free;

  ptb_ram #(.DEPTH(MAX_NODES - 1), .WIDTH(SW)) u_text (
    .clk(clk), .we(text_we), .waddr(text_waddr), .wdata(text_wdata),
    .raddr(text_raddr), .rdata(text_q)
  );

  ptb_ram #(.DEPTH(MAX_NODES), .WIDTH(MW)) u_node (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_q)
  );

  ptb_ram #(.DEPTH(CDEPTH), .WIDTH(NW)) u_child (
    .clk(clk), .we(child_we), .waddr(child_waddr), .wdata(child_wdata),
    .raddr(child_raddr), .rdata(child_q)
  );

  // node record: link, length, parent, letter
  assign nd_link = node_q[MW-1 -: NW];
  assign nd_len  = node_q[2*NW+SW-1 -: NW];
  assign nd_par  = node_q[NW+SW-1 -: NW];
  assign nd_sym  = node_q[SW-1:0];

  assign in_fire  = symbols.valid && symbols.ready;
  assign sym_ok   = int'(symbols.symbol) < ALPHABET;
  assign pos_eff  = symbols.restart ? '0 : pos;
  assign full     = pos_eff >= TW'(MAX_NODES - 2);
  assign out_free = !results.valid || results.ready;

  // empty root has length 0 and links to the imaginary root
  assign lk_len  = (p == '0) ? '0 : $signed(LW'(nd_len));
  assign lk_link = (p == '0) ? NW'(1) : nd_link;

  assign pos_s    = $signed(LW'(pos));
  assign idx      = pos_s - lk_len - $signed(LW'(1));
  assign idx_ok   = (idx > 0) && (idx < pos_s);
  assign text_hit = text_q == sym_r;

  assign slot_calc = AW'(p) * AW'(ALPHABET) + AW'(sym_r);
  assign cand_ok   = (cand >= NW'(2)) && (CW'(cand) < cnt) && (nd_par == p) &&
                     (nd_sym == sym_r);
  assign new_len   = NW'(cur_len + $signed(LW'(2)));

  always_comb begin
    state_next = state;
    unique case (state)
      ptb_pkg::S_IDLE: begin
        if (in_fire) begin
          if (sym_ok && !full) begin
            state_next = ptb_pkg::S_WALK;
          end else begin
            state_next = ptb_pkg::S_EMIT;
          end
        end
      end
      ptb_pkg::S_WALK: begin
        if (p == NW'(1)) begin
          state_next = ptb_pkg::S_CRD;
        end else begin
          state_next = ptb_pkg::S_LEN;
        end
      end
      ptb_pkg::S_LEN: begin
        if (idx_ok) begin
          state_next = ptb_pkg::S_TXT;
        end else begin
          state_next = ptb_pkg::S_WALK;
        end
      end
      ptb_pkg::S_TXT: begin
        if (text_hit) begin
          state_next = ptb_pkg::S_CRD;
        end else begin
          state_next = ptb_pkg::S_WALK;
        end
      end
      ptb_pkg::S_CRD:  state_next = ptb_pkg::S_CVER;
      ptb_pkg::S_CVER: state_next = ptb_pkg::S_CCHK;
      ptb_pkg::S_CCHK: begin
        if (second) begin
          state_next = ptb_pkg::S_MAKE;
        end else if (cand_ok) begin
          state_next = ptb_pkg::S_EMIT;
        end else if (cur == NW'(1)) begin
          state_next = ptb_pkg::S_MAKE;
        end else begin
          state_next = ptb_pkg::S_WALK;
        end
      end
      ptb_pkg::S_MAKE: state_next = ptb_pkg::S_EMIT;
      ptb_pkg::S_EMIT: begin
        if (out_free) begin
          state_next = ptb_pkg::S_IDLE;
        end
      end
      default: state_next = ptb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    symbols.ready = (state == ptb_pkg::S_IDLE);

    text_we    = in_fire && sym_ok && !full;
    text_waddr = pos_eff + 1'b1;
    text_wdata = symbols.symbol;
    text_raddr = idx[TW-1:0];

    node_raddr = (state == ptb_pkg::S_CVER) ? child_q : p;
    node_we    = (state == ptb_pkg::S_MAKE);
    node_waddr = NW'(cnt);
    node_wdata = {new_link, new_len, cur, sym_r};

    child_raddr = slot_calc;
    child_we    = (state == ptb_pkg::S_MAKE);
    child_waddr = cur_slot;
    child_wdata = NW'(cnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ptb_pkg::S_IDLE;
      pos           <= '0;
      cnt           <= CW'(2);
      last          <= '0;
      last_len      <= '0;
      last_link     <= NW'(1);
      second        <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (results.valid && results.ready) begin
        results.valid <= 1'b0;
      end
      unique case (state)
        ptb_pkg::S_IDLE: begin
          if (in_fire) begin
            sym_r     <= symbols.symbol;
            created_r <= 1'b0;
            over_r    <= sym_ok && full;
            second    <= 1'b0;
            if (symbols.restart) begin
              pos       <= '0;
              cnt       <= CW'(2);
              last      <= '0;
              last_len  <= '0;
              last_link <= NW'(1);
            end
            if (sym_ok && !full) begin
              pos <= pos_eff + 1'b1;
              p   <= symbols.restart ? '0 : last;
            end
          end
        end
        ptb_pkg::S_WALK: begin
          if (p == NW'(1) && !second) begin
            cur     <= p;
            cur_len <= '1;
          end
        end
        ptb_pkg::S_LEN: begin
          p_len  <= lk_len;
          p_link <= lk_link;
          if (!idx_ok) begin
            p <= lk_link;
          end
        end
        ptb_pkg::S_TXT: begin
          if (text_hit) begin
            if (!second) begin
              cur      <= p;
              cur_len  <= p_len;
              cur_link <= p_link;
            end
          end else begin
            p <= p_link;
          end
        end
        ptb_pkg::S_CRD: begin
          if (!second) begin
            cur_slot <= slot_calc;
          end
        end
        ptb_pkg::S_CVER: cand <= child_q;
        ptb_pkg::S_CCHK: begin
          if (second) begin
            if (cand_ok) begin
              new_link <= cand;
            end else begin
              new_link <= '0;
            end
          end else if (cand_ok) begin
            last      <= cand;
            last_len  <= nd_len;
            last_link <= nd_link;
          end else if (cur == NW'(1)) begin
            new_link <= '0;
          end else begin
            p      <= cur_link;
            second <= 1'b1;
          end
        end
        ptb_pkg::S_MAKE: begin
          last      <= NW'(cnt);
          last_len  <= new_len;
          last_link <= new_link;
          cnt       <= cnt + 1'b1;
          created_r <= 1'b1;
        end
        ptb_pkg::S_EMIT: begin
          if (out_free) begin
            results.valid         <= 1'b1;
            results.suffix_node   <= NODE_OW'(last);
            results.suffix_length <= LEN_OW'(last_len);
            results.created       <= created_r;
            results.link_node     <= NODE_OW'(last_link);
            results.node_total    <= TOTAL_OW'(cnt);
            results.overflow      <= over_r;
          end
        end
        default: ;
      endcase
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt >= CW'(2) && cnt <= CW'(MAX_NODES))
    else $error("node count out of range");

  a_last_known: assert property (@(posedge clk) disable iff (rst)
    CW'(last) < cnt)
    else $error("last node beyond node count");

  a_make_room: assert property (@(posedge clk) disable iff (rst)
    state == ptb_pkg::S_MAKE |-> cnt < CW'(MAX_NODES))
    else $error("node created with node table full");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= TW'(MAX_NODES - 2))
    else $error("text position beyond capacity");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ptb_pkg::S_EMIT && out_free) |=> results.valid &&
      state == ptb_pkg::S_IDLE)
    else $error("result not presented after emit");

endmodule
